### rtl/fcbl_pkg.sv
package fcbl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W   = 2;
  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int FAIL_W = 16;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_DATA_W = 24;

  localparam int OUT_FOUND_BIT   = 0;
  localparam int OUT_BLOCKED_BIT = 1;
  localparam int OUT_FAIL_LSB    = 2;
  localparam int OUT_DROPPED_BIT = OUT_FAIL_LSB + FAIL_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_FAILURE = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT   = 1'd1;

  localparam logic [FAIL_W-1:0] RETRY_LIMIT_RST = 16'd5;
  localparam logic [TIME_W-1:0] AGE_LIMIT_RST   = TIME_W'(3 * 24 * 3600);
  localparam logic [FAIL_W-1:0] FAIL_MAX        = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] first;
    logic [FAIL_W-1:0] failures;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd_last;
    logic write;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic             match;
    logic             scan_done;
    logic             hit;
    logic             full;
    logic [OP_W-1:0]  op;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

### rtl/failure_count_blocklist_table_top.sv
// Peer failure table. Each transfer on s_axis carries one operation (record
// failure, remove, query) and gives exactly one result transfer on m_axis.
// The entry RAM has one read port and the address search reads one entry per
// cycle until a match or the end of the table. Only one operation is in
// flight; a finished result waits in the output register while the next
// operation is taken. Stores of up to 256 entries; no clearing pass after
// reset. The user must write limits through cfg_* only while no operation is
// open; the block itself does not enforce this.
module failure_count_blocklist_table_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fcbl_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // peer_address, now_seconds
  input  logic [fcbl_pkg::IN_USER_W-1:0]      s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fcbl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // found, blocked, failures, dropped
  input  logic                                cfg_wr_en,
  input  logic [fcbl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcbl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [fcbl_pkg::FAIL_W-1:0] retry_limit;
  logic [fcbl_pkg::TIME_W-1:0] age_limit;
  fcbl_pkg::dp_cmd_t           cmd;
  fcbl_pkg::dp_stat_t          stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= fcbl_pkg::RETRY_LIMIT_RST;
      age_limit   <= fcbl_pkg::AGE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fcbl_pkg::REG_RETRY_LIMIT: retry_limit <= cfg_data[fcbl_pkg::FAIL_W-1:0];
        fcbl_pkg::REG_AGE_LIMIT:   age_limit   <= cfg_data[fcbl_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  fcbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcbl_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (s_axis_tuser),
    .in_addr     (s_axis_tdata[fcbl_pkg::ADDR_W-1:0]),
    .in_now      (s_axis_tdata[fcbl_pkg::ADDR_W +: fcbl_pkg::TIME_W]),
    .retry_limit (retry_limit),
    .age_limit   (age_limit),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= fcbl_pkg::CNT_W'(fcbl_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (stat.count == $past(stat.count)) ||
             (stat.count == $past(stat.count) + 1'b1) ||
             (stat.count == $past(stat.count) - 1'b1))
    else $error("entry count moved by more than one");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second operation taken while one is open");

  a_drop_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[fcbl_pkg::OUT_DROPPED_BIT] &&
                        m_axis_tdata[fcbl_pkg::OUT_FOUND_BIT]))
    else $error("drop reported for a stored peer");
`endif

endmodule

### rtl/fcbl_ctrl.sv
module fcbl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcbl_pkg::dp_stat_t stat,
  output fcbl_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RDLAST = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.match || stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.op)
          fcbl_pkg::OP_FAILURE: begin
            state_next = (stat.hit || !stat.full) ? S_WRITE : S_FIN;
          end
          fcbl_pkg::OP_REMOVE: begin
            state_next = stat.hit ? S_RDLAST : S_FIN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_RDLAST: begin
        cmd.rd_last = 1'b1;
        state_next  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fcbl_datapath.sv
module fcbl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fcbl_pkg::dp_cmd_t                   cmd,
  output fcbl_pkg::dp_stat_t                  stat,
  input  logic [fcbl_pkg::OP_W-1:0]           in_op,
  input  logic [fcbl_pkg::ADDR_W-1:0]         in_addr,
  input  logic [fcbl_pkg::TIME_W-1:0]         in_now,
  input  logic [fcbl_pkg::FAIL_W-1:0]         retry_limit,
  input  logic [fcbl_pkg::TIME_W-1:0]         age_limit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fcbl_pkg::OUT_DATA_W-1:0]     out_data
);

  fcbl_pkg::entry_t mem [fcbl_pkg::TABLE_DEPTH];

  logic [fcbl_pkg::OP_W-1:0]   op_q;
  logic [fcbl_pkg::ADDR_W-1:0] addr_q;
  logic [fcbl_pkg::TIME_W-1:0] now_q;
  logic [fcbl_pkg::CNT_W-1:0]  count;
  logic [fcbl_pkg::CNT_W-1:0]  scan_idx;
  logic                        rd_pending;
  logic [fcbl_pkg::IDX_W-1:0]  rd_idx;
  fcbl_pkg::entry_t            rd_data;
  logic                        hit;
  logic [fcbl_pkg::IDX_W-1:0]  slot;
  logic [fcbl_pkg::TIME_W-1:0] ent_first;
  logic [fcbl_pkg::FAIL_W-1:0] fail_cnt;

  logic                        more;
  logic                        match;
  logic [fcbl_pkg::CNT_W-1:0]  count_m1;
  logic                        rd_en;
  logic [fcbl_pkg::IDX_W-1:0]  rd_addr;
  logic [fcbl_pkg::FAIL_W-1:0] fail_inc;
  logic [fcbl_pkg::IDX_W-1:0]  wr_idx;
  fcbl_pkg::entry_t            wr_entry;
  logic [fcbl_pkg::TIME_W-1:0] age;
  logic                        res_found;
  logic                        res_blocked;
  logic [fcbl_pkg::FAIL_W-1:0] res_failures;
  logic                        res_dropped;

  assign more     = (scan_idx < count);
  assign match    = rd_pending && (rd_data.addr == addr_q);
  assign count_m1 = count - 1'b1;
  assign rd_en    = (cmd.scan && more) || cmd.rd_last;
  assign rd_addr  = cmd.rd_last ? count_m1[fcbl_pkg::IDX_W-1:0]
                                : scan_idx[fcbl_pkg::IDX_W-1:0];
  assign fail_inc = (fail_cnt == fcbl_pkg::FAIL_MAX) ? fail_cnt : fail_cnt + 1'b1;

  always_comb begin
    if (op_q == fcbl_pkg::OP_REMOVE) begin
      wr_idx   = slot;
      wr_entry = rd_data;
    end else if (hit) begin
      wr_idx   = slot;
      wr_entry = '{addr: addr_q, first: ent_first, failures: fail_inc};
    end else begin
      wr_idx   = count[fcbl_pkg::IDX_W-1:0];
      wr_entry = '{addr: addr_q, first: now_q, failures: fcbl_pkg::FAIL_W'(1)};
    end
  end

  // entry RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_pending <= 1'b0;
      end else if (cmd.scan) begin
        rd_pending <= more;
      end
      if (cmd.write) begin
        if (op_q == fcbl_pkg::OP_REMOVE) begin
          count <= count_m1;
        end else if (!hit) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_op;
      addr_q   <= in_addr;
      now_q    <= in_now;
      scan_idx <= '0;
      hit      <= 1'b0;
      fail_cnt <= '0;
    end
    if (cmd.scan) begin
      if (more) begin
        scan_idx <= scan_idx + 1'b1;
        rd_idx   <= scan_idx[fcbl_pkg::IDX_W-1:0];
      end
      if (match) begin
        hit       <= 1'b1;
        slot      <= rd_idx;
        ent_first <= rd_data.first;
        fail_cnt  <= rd_data.failures;
      end
    end
    if (cmd.write && (op_q == fcbl_pkg::OP_FAILURE)) begin
      fail_cnt <= hit ? fail_inc : fcbl_pkg::FAIL_W'(1);
    end
    if (cmd.finish) begin
      out_data <= {{(fcbl_pkg::OUT_DATA_W - fcbl_pkg::OUT_DROPPED_BIT - 1){1'b0}},
                   res_dropped, res_failures, res_blocked, res_found};
    end
  end

  // clock behind first failure counts as age zero
  assign age = (now_q >= ent_first) ? (now_q - ent_first) : '0;

  assign res_found    = hit && ((op_q == fcbl_pkg::OP_FAILURE) ||
                                (op_q == fcbl_pkg::OP_REMOVE) ||
                                (op_q == fcbl_pkg::OP_QUERY));
  assign res_blocked  = hit && (op_q == fcbl_pkg::OP_QUERY) &&
                        ((age > age_limit) || (fail_cnt >= retry_limit));
  assign res_failures = ((op_q == fcbl_pkg::OP_FAILURE) || (op_q == fcbl_pkg::OP_QUERY))
                        ? fail_cnt : '0;
  assign res_dropped  = (op_q == fcbl_pkg::OP_FAILURE) && !hit && (fail_cnt == '0);

  assign stat.match     = match;
  assign stat.scan_done = !rd_pending && !more;
  assign stat.hit       = hit;
  assign stat.full      = (count == fcbl_pkg::CNT_W'(fcbl_pkg::TABLE_DEPTH));
  assign stat.op        = op_q;
  assign stat.out_busy  = out_valid && !out_ready;
  assign stat.count     = count;

endmodule

### bench/failure_count_blocklist_table_top_test.sv
module failure_count_blocklist_table_top_test;

  localparam logic [fcbl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE   = 300;
  localparam int LONG_STALL  = 1500;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic                        found;
    logic                        blocked;
    logic [fcbl_pkg::FAIL_W-1:0] failures;
    logic                        dropped;
  } verdict_t;

  class failure_table_mirror;
    logic [fcbl_pkg::ADDR_W-1:0] addr_tab[fcbl_pkg::TABLE_DEPTH];
    logic [fcbl_pkg::FAIL_W-1:0] fail_tab[fcbl_pkg::TABLE_DEPTH];
    logic [fcbl_pkg::TIME_W-1:0] first_tab[fcbl_pkg::TABLE_DEPTH];
    int unsigned                 stored;
    logic [fcbl_pkg::FAIL_W-1:0] retry_limit;
    logic [fcbl_pkg::TIME_W-1:0] age_limit;
    verdict_t                    due_verdicts[$];
    int unsigned                 mismatches;
    int unsigned                 checked;

    function new();
      stored      = 0;
      retry_limit = fcbl_pkg::RETRY_LIMIT_RST;
      age_limit   = fcbl_pkg::AGE_LIMIT_RST;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function int lookup(logic [fcbl_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < stored; i++) begin
        if (addr_tab[i] == addr) return i;
      end
      return -1;
    endfunction

    function void set_limit(logic [fcbl_pkg::CFG_IDX_W-1:0] idx,
                            logic [fcbl_pkg::CFG_DATA_W-1:0] value);
      if (idx == fcbl_pkg::REG_RETRY_LIMIT) retry_limit = value[fcbl_pkg::FAIL_W-1:0];
      else if (idx == fcbl_pkg::REG_AGE_LIMIT) age_limit = value[fcbl_pkg::TIME_W-1:0];
    endfunction

    function void note_op(logic [fcbl_pkg::OP_W-1:0] op, logic [fcbl_pkg::ADDR_W-1:0] addr,
                          logic [fcbl_pkg::TIME_W-1:0] now);
      int                          slot;
      int unsigned                 last;
      logic [fcbl_pkg::TIME_W-1:0] age;
      verdict_t                    v;
      slot = lookup(addr);
      v    = '0;
      case (op)
        fcbl_pkg::OP_FAILURE: begin
          if (slot >= 0) begin
            v.found = 1'b1;
            if (fail_tab[slot] != fcbl_pkg::FAIL_MAX) fail_tab[slot] = fail_tab[slot] + 1'b1;
            v.failures = fail_tab[slot];
          end else if (stored < fcbl_pkg::TABLE_DEPTH) begin
            addr_tab[stored]  = addr;
            fail_tab[stored]  = fcbl_pkg::FAIL_W'(1);
            first_tab[stored] = now;
            stored++;
            v.failures = fcbl_pkg::FAIL_W'(1);
          end else begin
            v.dropped = 1'b1;
          end
        end
        fcbl_pkg::OP_REMOVE: begin
          if (slot >= 0) begin
            last            = stored - 1;
            v.found         = 1'b1;
            addr_tab[slot]  = addr_tab[last];
            fail_tab[slot]  = fail_tab[last];
            first_tab[slot] = first_tab[last];
            stored          = last;
          end
        end
        fcbl_pkg::OP_QUERY: begin
          if (slot >= 0) begin
            age        = (now >= first_tab[slot]) ? now - first_tab[slot] : '0;
            v.found    = 1'b1;
            v.failures = fail_tab[slot];
            v.blocked  = (age > age_limit) || (fail_tab[slot] >= retry_limit);
          end
        end
        default: ;
      endcase
      due_verdicts.push_back(v);
    endfunction

    function void match_field(string name, logic [fcbl_pkg::FAIL_W-1:0] want,
                              logic [fcbl_pkg::FAIL_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_verdict(logic [fcbl_pkg::OUT_DATA_W-1:0] data);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, data);
        return;
      end
      want = due_verdicts.pop_front();
      checked++;
      match_field("found", fcbl_pkg::FAIL_W'(want.found),
                  fcbl_pkg::FAIL_W'(data[fcbl_pkg::OUT_FOUND_BIT]));
      match_field("blocked", fcbl_pkg::FAIL_W'(want.blocked),
                  fcbl_pkg::FAIL_W'(data[fcbl_pkg::OUT_BLOCKED_BIT]));
      match_field("failures", want.failures,
                  data[fcbl_pkg::OUT_FAIL_LSB +: fcbl_pkg::FAIL_W]);
      match_field("dropped", fcbl_pkg::FAIL_W'(want.dropped),
                  fcbl_pkg::FAIL_W'(data[fcbl_pkg::OUT_DROPPED_BIT]));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [fcbl_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // peer_address, now_seconds
  logic [fcbl_pkg::IN_USER_W-1:0]  s_axis_tuser;   // op
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [fcbl_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // found, blocked, failures, dropped
  logic                            cfg_wr_en;
  logic [fcbl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fcbl_pkg::CFG_DATA_W-1:0] cfg_data;

  failure_count_blocklist_table_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  failure_table_mirror table_mirror = new();

  int unsigned                 send_idle_pct;
  int unsigned                 recv_idle_pct;
  bit                          stall_go;
  int unsigned                 ops_sent;
  int unsigned                 cycle_count = 0;
  logic [fcbl_pkg::TIME_W-1:0] clock_s;
  logic [fcbl_pkg::ADDR_W-1:0] pool[POOL_SIZE];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, table_mirror.due_verdicts.size());
      $display("failure_count_blocklist_table_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) table_mirror.check_verdict(m_axis_tdata);
  end

  // result side ready; a long hold is counted here
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_go) begin
        stall_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [fcbl_pkg::ADDR_W-1:0] rand_addr48();
    logic [fcbl_pkg::ADDR_W-1:0] a;
    a[31:0]  = $urandom;
    a[47:32] = 16'($urandom);
    return a;
  endfunction

  function automatic logic [fcbl_pkg::TIME_W-1:0] next_now();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      clock_s = clock_s + $urandom_range(0, 50000);
      return clock_s;
    end else if (r < 85) begin
      return clock_s - $urandom_range(0, 2000);
    end
    return $urandom;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [fcbl_pkg::OP_W-1:0] op,
                           input logic [fcbl_pkg::ADDR_W-1:0] addr,
                           input logic [fcbl_pkg::TIME_W-1:0] now);
    int unsigned gaps;
    if ($urandom_range(99) < send_idle_pct) begin
      gaps = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, addr};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    table_mirror.note_op(op, addr, now);
    ops_sent++;
    @(negedge clk);
  endtask

  task automatic random_item(input int pool_n);
    int unsigned                 r;
    logic [fcbl_pkg::OP_W-1:0]   op;
    logic [fcbl_pkg::ADDR_W-1:0] addr;
    r    = $urandom_range(99);
    op   = (r < 45) ? fcbl_pkg::OP_FAILURE : (r < 65) ? fcbl_pkg::OP_REMOVE :
           (r < 95) ? fcbl_pkg::OP_QUERY : OP_UNUSED;
    addr = ($urandom_range(9) == 0) ? rand_addr48() : pool[$urandom_range(pool_n - 1)];
    send_item(op, addr, next_now());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (table_mirror.due_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic set_limits(input logic [fcbl_pkg::FAIL_W-1:0] retry,
                            input logic [fcbl_pkg::TIME_W-1:0] age);
    cfg_wr_en <= 1'b1;
    cfg_index <= fcbl_pkg::REG_RETRY_LIMIT;
    cfg_data  <= {{(fcbl_pkg::CFG_DATA_W - fcbl_pkg::FAIL_W){1'b0}}, retry};
    table_mirror.set_limit(fcbl_pkg::REG_RETRY_LIMIT,
                           {{(fcbl_pkg::CFG_DATA_W - fcbl_pkg::FAIL_W){1'b0}}, retry});
    @(negedge clk);
    cfg_index <= fcbl_pkg::REG_AGE_LIMIT;
    cfg_data  <= age;
    table_mirror.set_limit(fcbl_pkg::REG_AGE_LIMIT, age);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [fcbl_pkg::ADDR_W-1:0] a_lo;
    logic [fcbl_pkg::ADDR_W-1:0] a_hi;
    logic [fcbl_pkg::ADDR_W-1:0] a_mid;
    int                          i;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    stall_go      = 1'b0;
    ops_sent      = 0;
    clock_s       = 32'd1000000;
    send_idle_pct = 13;
    recv_idle_pct = 57;
    pool[0] = '0;
    pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) pool[i] = rand_addr48();
    a_lo  = pool[0];
    a_hi  = pool[1];
    a_mid = pool[2];

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset limits
    send_item(fcbl_pkg::OP_FAILURE, a_lo, 32'd0);
    send_item(fcbl_pkg::OP_FAILURE, a_lo, 32'd100);
    send_item(fcbl_pkg::OP_QUERY, a_lo, 32'hFFFF_FFFF);
    send_item(fcbl_pkg::OP_FAILURE, a_hi, 32'hFFFF_FFFF);
    send_item(fcbl_pkg::OP_QUERY, a_hi, 32'd5);
    send_item(fcbl_pkg::OP_QUERY, a_mid, 32'd7);
    send_item(fcbl_pkg::OP_REMOVE, a_mid, 32'd0);
    send_item(fcbl_pkg::OP_REMOVE, a_lo, 32'd0);
    send_item(fcbl_pkg::OP_QUERY, a_hi, 32'd300000);
    send_item(OP_UNUSED, a_hi, 32'hFFFF_FFFF);
    repeat (4) send_item(fcbl_pkg::OP_FAILURE, a_hi, 32'd10);
    send_item(fcbl_pkg::OP_QUERY, a_hi, 32'd10);
    send_item(fcbl_pkg::OP_FAILURE, a_mid, 32'd1000);
    send_item(fcbl_pkg::OP_QUERY, a_mid, 32'd1000 + fcbl_pkg::AGE_LIMIT_RST);
    send_item(fcbl_pkg::OP_QUERY, a_mid, 32'd1001 + fcbl_pkg::AGE_LIMIT_RST);
    send_item(fcbl_pkg::OP_REMOVE, a_hi, 32'd0);
    send_item(fcbl_pkg::OP_REMOVE, a_mid, 32'd0);
    drain();

    // lowest limits: every stored peer is blocked
    set_limits('0, '0);
    repeat (150) random_item(24);
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 13;
    set_limits('1, '1);
    @(posedge clk);
    stall_go = 1'b1;
    @(negedge clk);
    for (i = 0; i < POOL_SIZE && table_mirror.stored < fcbl_pkg::TABLE_DEPTH; i++) begin
      if (table_mirror.lookup(pool[i]) < 0)
        send_item(fcbl_pkg::OP_FAILURE, pool[i], next_now());
      if (i % 16 == 0)
        send_item(fcbl_pkg::OP_QUERY, pool[$urandom_range(POOL_SIZE - 1)], next_now());
    end
    // table full: new peers are dropped
    for (i = 0; i < POOL_SIZE; i++) begin
      if (table_mirror.lookup(pool[i]) < 0 && $urandom_range(3) == 0)
        send_item(fcbl_pkg::OP_FAILURE, pool[i], next_now());
    end
    repeat (20) random_item(POOL_SIZE);
    drain();

    set_limits(16'd3, $urandom_range(1000, 500000));
    repeat (120) random_item(POOL_SIZE);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(16'($urandom_range(1, 10)), 32'd1000);
    repeat (100) random_item(40);
    drain();

    repeat (20) @(posedge clk);
    if (table_mirror.due_verdicts.size() != 0) begin
      table_mirror.mismatches++;
      $display("%0t: results missing, expected %0d more, got none", $time,
               table_mirror.due_verdicts.size());
    end
    $display("Ran %0d operations, %0d results checked, %0d mismatches.", ops_sent,
             table_mirror.checked, table_mirror.mismatches);
    $display("Covered five limit settings, a full table with drops and a long output stall.");
    if (table_mirror.mismatches == 0) begin
      $display("failure_count_blocklist_table_top test passed");
    end else begin
      $display("failure_count_blocklist_table_top test failed");
    end
    $finish;
  end

endmodule
